[rtl/icov_pkg.sv]
package icov_pkg;

  localparam int LENGTH_W = 11;
  localparam int POS_FIELD_W = 16;
  localparam int POS_W = 10;
  localparam int DEPTH_W = 16;
  localparam int CMP_W = 18;
  localparam int LANES = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [LENGTH_W-1:0] LENGTH_RESET = 11'd1024;

  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_USED_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PENALIZE = 1'd1;

  typedef struct packed {
    logic                          req_type;
    logic                          reverse_strand;
    logic                          pair_match;
    logic signed [POS_FIELD_W-1:0] start_pos;
    logic signed [POS_FIELD_W-1:0] end_pos;
  } icov_in_t;

  typedef struct packed {
    logic               accepted;
    logic [POS_W-1:0]   position;
    logic [DEPTH_W-1:0] fwd_depth;
    logic [DEPTH_W-1:0] rev_depth;
    logic [DEPTH_W-1:0] combined_depth;
    logic [DEPTH_W-1:0] pair_depth;
    logic               last_position;
    logic [DEPTH_W-1:0] min_combined;
    logic [DEPTH_W-1:0] min_pair;
  } icov_out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } icov_state_t;

  typedef struct packed {
    logic commit;
    logic penalize;
  } icov_rd_ctl_t;

endpackage

[rtl/interval_coverage_accumulator.sv]
// Interval coverage accumulator.
// Items enter on in_valid/in_ready as icov_in_t. An add item clips its interval
// to the region and bumps the start and end counters of its strand (and the
// pair counters when pair-matched). A read item reports the next position and
// clears the counters it used. Every item gives exactly one item on
// out_valid/out_ready.
// Each item passes through ST_IDLE, where on acceptance the start and end
// memories are read, and then ST_UPDATE, where the counters are modified and
// written back and the output register is loaded; ST_UPDATE waits while out_valid
// is high and out_ready is low. The block takes no new item until the write-back
// of the last one is done, set by the single read-modify-write of the memories.
// After reset a clearing pass writes zeros to all MAX_POSITIONS entries, one a
// cycle, with in_ready low until the pass is done. Registers reset to used_length
// 1024 and penalize 0; cfg_ready is always high.
// When out_ready is low the output register holds its item; one more item may
// be accepted and waits in the write-back stage until the register frees up.
module interval_coverage_accumulator #(
  parameter int MAX_POSITIONS = 1024,
  parameter int COUNT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  icov_pkg::icov_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output icov_pkg::icov_out_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [icov_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [icov_pkg::LENGTH_W-1:0]    cfg_data
);
  import icov_pkg::*;

  localparam int C = COUNT_BITS;
  localparam int ADDR_W = $clog2(MAX_POSITIONS);
  localparam int WORD_W = LANES * C;
  localparam logic [C-1:0] COUNT_MAX = {C{1'b1}};

  icov_state_t state, state_next;

  logic [LENGTH_W-1:0] used_length;
  logic                penalize;
  logic [ADDR_W-1:0]   clr_idx;

  logic              item_read;
  logic              item_keep;
  logic [LANES-1:0]  item_inc;
  logic [ADDR_W-1:0] s_addr;
  logic [ADDR_W-1:0] e_addr;

  logic [CMP_W-1:0]        ul_ext;
  logic [CMP_W-1:0]        eff_len;
  logic signed [CMP_W-1:0] len_s;
  logic signed [CMP_W-1:0] s_in;
  logic signed [CMP_W-1:0] e_in;
  logic signed [CMP_W-1:0] s_clip;
  logic signed [CMP_W-1:0] e_clip;
  logic                    keep_in;

  logic              mem_we;
  logic [ADDR_W-1:0] s_waddr, e_waddr, s_raddr, e_raddr;
  logic [WORD_W-1:0] s_wdata, e_wdata, s_rdata, e_rdata, s_bump, e_bump;

  logic         out_load;
  icov_out_t    out_next;
  icov_rd_ctl_t rd_ctl;

  logic [ADDR_W-1:0] rd_index;
  logic [C-1:0] rd_fwd, rd_rev, rd_pair, rd_comb, rd_min_c, rd_min_p;
  logic         rd_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_length <= LENGTH_RESET;
      penalize <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_USED_LENGTH: used_length <= cfg_data;
        CFG_PENALIZE:    penalize <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective length and interval clipping
  assign ul_ext = CMP_W'(used_length);
  always_comb begin
    if (ul_ext == '0) begin
      eff_len = CMP_W'(1);
    end else if (ul_ext > CMP_W'(MAX_POSITIONS)) begin
      eff_len = CMP_W'(MAX_POSITIONS);
    end else begin
      eff_len = ul_ext;
    end
  end

  assign len_s = $signed(eff_len);
  assign s_in = CMP_W'(in_data.start_pos);
  assign e_in = CMP_W'(in_data.end_pos);
  assign s_clip = (s_in < 0) ? '0 : s_in;
  assign e_clip = (e_in >= len_s) ? len_s - CMP_W'(1) : e_in;
  assign keep_in = !((s_clip > len_s - CMP_W'(1)) || (e_clip < 0));

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_read <= (in_data.req_type == REQ_READ);
      item_keep <= keep_in;
      item_inc <= {!in_data.reverse_strand, in_data.reverse_strand, in_data.pair_match};
      s_addr <= s_raddr;
      e_addr <= e_raddr;
    end
  end

  // memory addresses
  always_comb begin
    if (state == ST_IDLE) begin
      if (in_data.req_type == REQ_READ) begin
        s_raddr = rd_index;
        e_raddr = rd_index;
      end else begin
        s_raddr = ADDR_W'(s_clip);
        e_raddr = ADDR_W'(e_clip);
      end
    end else begin
      s_raddr = s_addr;
      e_raddr = e_addr;
    end
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      if (item_inc[k] && (s_rdata[k*C +: C] != COUNT_MAX)) begin
        s_bump[k*C +: C] = s_rdata[k*C +: C] + C'(1);
      end else begin
        s_bump[k*C +: C] = s_rdata[k*C +: C];
      end
      if (item_inc[k] && (e_rdata[k*C +: C] != COUNT_MAX)) begin
        e_bump[k*C +: C] = e_rdata[k*C +: C] + C'(1);
      end else begin
        e_bump[k*C +: C] = e_rdata[k*C +: C];
      end
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    out_load = 1'b0;
    mem_we = 1'b0;
    s_waddr = s_addr;
    e_waddr = e_addr;
    s_wdata = '0;
    e_wdata = '0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        s_waddr = clr_idx;
        e_waddr = clr_idx;
        if (clr_idx == ADDR_W'(MAX_POSITIONS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          mem_we = item_read || item_keep;
          if (!item_read) begin
            s_wdata = s_bump;
            e_wdata = e_bump;
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + ADDR_W'(1);
      end
    end
  end

  icov_mem #(
    .DEPTH(MAX_POSITIONS),
    .WIDTH(WORD_W)
  ) u_start_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .raddr(s_raddr),
    .rdata(s_rdata)
  );

  icov_mem #(
    .DEPTH(MAX_POSITIONS),
    .WIDTH(WORD_W)
  ) u_end_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(e_waddr),
    .wdata(e_wdata),
    .raddr(e_raddr),
    .rdata(e_rdata)
  );

  assign rd_ctl.commit = out_load && item_read;
  assign rd_ctl.penalize = penalize;

  icov_reader #(
    .MAX_POSITIONS(MAX_POSITIONS),
    .COUNT_BITS(COUNT_BITS)
  ) u_reader (
    .clk           (clk),
    .rst           (rst),
    .ctl           (rd_ctl),
    .eff_len       (eff_len),
    .start_word    (s_rdata),
    .end_word      (e_rdata),
    .read_index    (rd_index),
    .fwd_depth     (rd_fwd),
    .rev_depth     (rd_rev),
    .pair_depth    (rd_pair),
    .combined_depth(rd_comb),
    .last_position (rd_last),
    .min_combined  (rd_min_c),
    .min_pair      (rd_min_p)
  );

  always_comb begin
    out_next = '0;
    if (item_read) begin
      out_next.position = POS_W'(rd_index);
      out_next.fwd_depth = DEPTH_W'(rd_fwd);
      out_next.rev_depth = DEPTH_W'(rd_rev);
      out_next.combined_depth = DEPTH_W'(rd_comb);
      out_next.pair_depth = DEPTH_W'(rd_pair);
      out_next.last_position = rd_last;
      if (rd_last) begin
        out_next.min_combined = DEPTH_W'(rd_min_c);
        out_next.min_pair = DEPTH_W'(rd_min_p);
      end
    end else begin
      out_next.accepted = item_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_update: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_UPDATE))
    else $error("accepted item did not enter write-back");

  a_last_wraps_index: assert property (@(posedge clk) disable iff (rst)
    (out_load && item_read && rd_last) |=> (rd_index == '0))
    else $error("read index not returned to zero after last position");

  a_clear_complete: assert property (@(posedge clk) disable iff (rst)
    $fell(state == ST_CLEAR) |-> ($past(clr_idx) == ADDR_W'(MAX_POSITIONS - 1)))
    else $error("clearing pass ended early");

  a_write_with_result: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state != ST_CLEAR)) |-> out_load)
    else $error("counter write without a result");
`endif

endmodule

[rtl/icov_mem.sv]
module icov_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/icov_reader.sv]
module icov_reader #(
  parameter int MAX_POSITIONS = 1024,
  parameter int COUNT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  icov_pkg::icov_rd_ctl_t                ctl,
  input  logic [icov_pkg::CMP_W-1:0]            eff_len,
  input  logic [icov_pkg::LANES*COUNT_BITS-1:0] start_word,
  input  logic [icov_pkg::LANES*COUNT_BITS-1:0] end_word,
  output logic [$clog2(MAX_POSITIONS)-1:0]      read_index,
  output logic [COUNT_BITS-1:0]                 fwd_depth,
  output logic [COUNT_BITS-1:0]                 rev_depth,
  output logic [COUNT_BITS-1:0]                 pair_depth,
  output logic [COUNT_BITS-1:0]                 combined_depth,
  output logic                                  last_position,
  output logic [COUNT_BITS-1:0]                 min_combined,
  output logic [COUNT_BITS-1:0]                 min_pair
);
  import icov_pkg::*;

  localparam int C = COUNT_BITS;
  localparam int ADDR_W = $clog2(MAX_POSITIONS);
  localparam logic [C-1:0] COUNT_MAX = {C{1'b1}};

  logic [C-1:0] run [LANES];
  logic [C-1:0] run_next [LANES];
  logic [C-1:0] depth [LANES];
  logic [C-1:0] min_c_run;
  logic [C-1:0] min_p_run;
  logic [C:0]   strand_sum;
  logic [C-1:0] disp;
  logic [C+2:0] disp4;
  logic [C+2:0] sum3;
  logic [C:0]   comb_full;
  logic [C-1:0] lo;

  // lane 2 forward, lane 1 reverse, lane 0 pair
  always_comb begin
    logic [C:0] s;
    logic [C-1:0] e;
    for (int k = 0; k < LANES; k++) begin
      s = {1'b0, run[k]} + {1'b0, start_word[k*C +: C]};
      depth[k] = s[C] ? COUNT_MAX : s[C-1:0];
      e = end_word[k*C +: C];
      run_next[k] = (depth[k] >= e) ? depth[k] - e : '0;
    end
  end

  assign fwd_depth = depth[2];
  assign rev_depth = depth[1];
  assign pair_depth = depth[0];

  assign strand_sum = {1'b0, fwd_depth} + {1'b0, rev_depth};
  assign disp = (fwd_depth > rev_depth) ? fwd_depth - rev_depth : rev_depth - fwd_depth;
  assign disp4 = {1'b0, disp, 2'b00};
  assign sum3 = {1'b0, strand_sum, 1'b0} + {2'b00, strand_sum};
  assign lo = (fwd_depth < rev_depth) ? fwd_depth : rev_depth;

  always_comb begin
    if (ctl.penalize && (disp4 > sum3)) begin
      comb_full = {lo, 1'b0};
    end else begin
      comb_full = strand_sum;
    end
  end

  assign combined_depth = comb_full[C] ? COUNT_MAX : comb_full[C-1:0];
  assign min_combined = (combined_depth < min_c_run) ? combined_depth : min_c_run;
  assign min_pair = (pair_depth < min_p_run) ? pair_depth : min_p_run;
  assign last_position = CMP_W'(read_index) >= (eff_len - CMP_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      read_index <= '0;
      min_c_run <= COUNT_MAX;
      min_p_run <= COUNT_MAX;
      for (int k = 0; k < LANES; k++) begin
        run[k] <= '0;
      end
    end else if (ctl.commit) begin
      if (last_position) begin
        read_index <= '0;
        min_c_run <= COUNT_MAX;
        min_p_run <= COUNT_MAX;
        for (int k = 0; k < LANES; k++) begin
          run[k] <= '0;
        end
      end else begin
        read_index <= read_index + ADDR_W'(1);
        min_c_run <= min_combined;
        min_p_run <= min_pair;
        for (int k = 0; k < LANES; k++) begin
          run[k] <= run_next[k];
        end
      end
    end
  end

endmodule
